// ----- hw/rtl/kdcp_pkg.sv -----
// kdcp_pkg: types, condition codes and compare helpers for the k-d tree
// child pruning unit. Has no dependencies; used by kdcp_key_eval and the top.
`default_nettype none

package kdcp_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TolW   = 31;
  localparam int unsigned OpW    = 3;
  localparam int unsigned CmpW   = CoordW + 2;

  // condition codes
  localparam logic [OpW-1:0] OP_NONE      = 3'd0;
  localparam logic [OpW-1:0] OP_LEFT      = 3'd1;
  localparam logic [OpW-1:0] OP_RIGHT     = 3'd2;
  localparam logic [OpW-1:0] OP_SAME      = 3'd3;
  localparam logic [OpW-1:0] OP_BELOW     = 3'd4;
  localparam logic [OpW-1:0] OP_ABOVE     = 3'd5;
  localparam logic [OpW-1:0] OP_CONTAINED = 3'd6;
  localparam logic [OpW-1:0] OP_INVALID   = 3'd7;

  // child mask encodings
  localparam logic [1:0] MASK_NONE = 2'b00;
  localparam logic [1:0] MASK_LOW  = 2'b01;
  localparam logic [1:0] MASK_HIGH = 2'b10;
  localparam logic [1:0] MASK_BOTH = 2'b11;

  typedef struct packed {
    logic [OpW-1:0]           opcode;
    logic signed [CoordW-1:0] split_coord;
    logic                     level_odd;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] box_high_x;
    logic signed [CoordW-1:0] box_high_y;
    logic                     last_key;
  } in_item_t;

  typedef struct packed {
    logic       descend_low;
    logic       descend_high;
    logic [1:0] child_count;
    logic       bad_condition;
  } out_item_t;

  typedef struct packed {
    logic [1:0] keep;
    logic       invalid;
  } key_verdict_t;

  // a + tol < b, exact in CmpW bits
  function automatic logic fuzzy_lt(input logic signed [CoordW-1:0] a,
                                    input logic signed [CoordW-1:0] b,
                                    input logic [TolW-1:0] tol);
    logic signed [CmpW-1:0] lhs;
    logic signed [CmpW-1:0] rhs;
    lhs = $signed({{2{a[CoordW-1]}}, a}) + $signed({3'b000, tol});
    rhs = $signed({{2{b[CoordW-1]}}, b});
    return lhs < rhs;
  endfunction

  // a > b + tol, exact in CmpW bits
  function automatic logic fuzzy_gt(input logic signed [CoordW-1:0] a,
                                    input logic signed [CoordW-1:0] b,
                                    input logic [TolW-1:0] tol);
    logic signed [CmpW-1:0] lhs;
    logic signed [CmpW-1:0] rhs;
    lhs = $signed({{2{a[CoordW-1]}}, a});
    rhs = $signed({{2{b[CoordW-1]}}, b}) + $signed({3'b000, tol});
    return lhs > rhs;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/kd_tree_child_pruning_unit.sv -----
// A key is evaluated from the input register; a last key writes its result to the
// output register once that is empty or read. Throughput: one key per cycle, unless
// a last key waits on a stalled output; the mask update is one compare stage per key.
// Reset (synchronous, rst_n low): both stages empty, child mask both, error clear,
// tolerance 0.
// Depends on kdcp_pkg and kdcp_key_eval.
`default_nettype none

module kd_tree_child_pruning_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [kdcp_pkg::TolW-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  kdcp_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output kdcp_pkg::out_item_t          out_item
);

  logic [kdcp_pkg::TolW-1:0] tolerance_r;
  logic                      key_valid_r;
  kdcp_pkg::in_item_t        key_r;
  logic [1:0]                mask_r;
  logic [1:0]                mask_nxt;
  logic                      err_r;
  logic                      err_nxt;
  logic                      out_valid_r;
  kdcp_pkg::out_item_t       out_item_r;
  kdcp_pkg::key_verdict_t    verdict;
  logic                      out_free;
  logic                      key_fire;
  logic                      in_fire;

  kdcp_key_eval u_eval (
    .item      (key_r),
    .tolerance (tolerance_r),
    .verdict   (verdict)
  );

  assign out_free = !out_valid_r || !out_stall;
  // a key with no result never waits on the output side
  assign key_fire = key_valid_r && (!key_r.last_key || out_free);
  assign in_stall = key_valid_r && !key_fire;
  assign in_fire  = in_valid && !in_stall;

  // empty mask freezes the node
  always_comb begin
    mask_nxt = mask_r;
    err_nxt  = err_r;
    if (mask_r != kdcp_pkg::MASK_NONE) begin
      mask_nxt = mask_r & verdict.keep;
      err_nxt  = err_r | verdict.invalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tolerance_r <= '0;
      key_valid_r <= 1'b0;
      mask_r      <= kdcp_pkg::MASK_BOTH;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) tolerance_r <= cfg_wr_data;

      if (in_fire)       key_valid_r <= 1'b1;
      else if (key_fire) key_valid_r <= 1'b0;

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      if (key_fire) begin
        if (key_r.last_key) begin
          mask_r      <= kdcp_pkg::MASK_BOTH;
          err_r       <= 1'b0;
          out_valid_r <= 1'b1;
        end else begin
          mask_r <= mask_nxt;
          err_r  <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) key_r <= in_item;
    if (key_fire && key_r.last_key) begin
      out_item_r.descend_low   <= mask_nxt[0];
      out_item_r.descend_high  <= mask_nxt[1];
      out_item_r.child_count   <= {1'b0, mask_nxt[0]} + {1'b0, mask_nxt[1]};
      out_item_r.bad_condition <= err_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- hw/rtl/kdcp_key_eval.sv -----
// kdcp_key_eval: combinational evaluation of one search key against the
// node split, giving the mask of children to keep. Depends on kdcp_pkg.
`default_nettype none

module kdcp_key_eval (
  input  kdcp_pkg::in_item_t          item,
  input  logic [kdcp_pkg::TolW-1:0]   tolerance,
  output kdcp_pkg::key_verdict_t      verdict
);

  logic signed [kdcp_pkg::CoordW-1:0] pt;
  logic signed [kdcp_pkg::CoordW-1:0] hi;
  logic                               pt_lt;
  logic                               pt_gt;
  logic                               hi_lt;
  logic                               on_x;

  // coordinates on the split axis
  assign on_x  = item.level_odd;
  assign pt    = on_x ? item.point_x : item.point_y;
  assign hi    = on_x ? item.box_high_x : item.box_high_y;
  assign pt_lt = kdcp_pkg::fuzzy_lt(pt, item.split_coord, tolerance);
  assign pt_gt = kdcp_pkg::fuzzy_gt(pt, item.split_coord, tolerance);
  assign hi_lt = kdcp_pkg::fuzzy_lt(hi, item.split_coord, tolerance);

  always_comb begin
    verdict.keep    = kdcp_pkg::MASK_BOTH;
    verdict.invalid = 1'b0;
    case (item.opcode)
      kdcp_pkg::OP_NONE: begin
        verdict.keep = kdcp_pkg::MASK_BOTH;
      end
      kdcp_pkg::OP_LEFT: begin
        if (on_x && pt_lt) verdict.keep = kdcp_pkg::MASK_LOW;
      end
      kdcp_pkg::OP_RIGHT: begin
        if (on_x && pt_gt) verdict.keep = kdcp_pkg::MASK_HIGH;
      end
      kdcp_pkg::OP_SAME: begin
        if (pt_lt)      verdict.keep = kdcp_pkg::MASK_LOW;
        else if (pt_gt) verdict.keep = kdcp_pkg::MASK_HIGH;
      end
      kdcp_pkg::OP_BELOW: begin
        if (!on_x && pt_lt) verdict.keep = kdcp_pkg::MASK_LOW;
      end
      kdcp_pkg::OP_ABOVE: begin
        if (!on_x && pt_gt) verdict.keep = kdcp_pkg::MASK_HIGH;
      end
      kdcp_pkg::OP_CONTAINED: begin
        // box compared as given, no reordering of corners
        if (hi_lt)      verdict.keep = kdcp_pkg::MASK_LOW;
        else if (pt_gt) verdict.keep = kdcp_pkg::MASK_HIGH;
      end
      kdcp_pkg::OP_INVALID: begin
        verdict.keep    = kdcp_pkg::MASK_NONE;
        verdict.invalid = 1'b1;
      end
      default: begin
        verdict.keep = kdcp_pkg::MASK_BOTH;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- bench/kd_tree_child_pruning_unit_test.sv -----
// Self-checking bench for kd_tree_child_pruning_unit: directed and random search keys,
// with a built-in child-selection predictor and a result scoreboard.
// Depends on kdcp_pkg and the unit's RTL only.
module kd_tree_child_pruning_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kdcp_pkg::*;

  localparam logic signed [CoordW-1:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [CoordW-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic [TolW-1:0]          TOL_MAX   = 31'h7fff_ffff;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [TolW-1:0]   cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;

  // predictor state
  logic [1:0]        live_children = MASK_BOTH;
  logic              saw_bad_code = 1'b0;
  logic [TolW-1:0]   margin = '0;
  out_item_t         pending_verdicts[$];

  // no idling on either side while set
  logic              calm = 1'b0;
  int unsigned       mismatches = 0;
  int unsigned       keys_sent = 0;
  int unsigned       verdicts_checked = 0;
  int unsigned       margins_used = 0;
  out_item_t         want;

  kd_tree_child_pruning_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #400_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic margin_lt(input longint a, input longint b);
    return a + longint'(margin) < b;
  endfunction

  function automatic logic margin_gt(input longint a, input longint b);
    return a > b + longint'(margin);
  endfunction

  // narrow the child mask by one key; queue the verdict on the node's last key
  function automatic void prune_children(input in_item_t k);
    longint     c;
    longint     px;
    longint     py;
    longint     p;
    longint     hi;
    logic [1:0] keep;
    out_item_t  r;
    c    = longint'($signed(k.split_coord));
    px   = longint'($signed(k.point_x));
    py   = longint'($signed(k.point_y));
    p    = k.level_odd ? px : py;
    hi   = k.level_odd ? longint'($signed(k.box_high_x)) : longint'($signed(k.box_high_y));
    keep = MASK_BOTH;
    if (live_children != MASK_NONE) begin
      case (k.opcode)
        OP_LEFT:  if (k.level_odd && margin_lt(px, c)) keep = MASK_LOW;
        OP_RIGHT: if (k.level_odd && margin_gt(px, c)) keep = MASK_HIGH;
        OP_SAME: begin
          if (margin_lt(p, c)) keep = MASK_LOW;
          else if (margin_gt(p, c)) keep = MASK_HIGH;
        end
        OP_BELOW: if (!k.level_odd && margin_lt(py, c)) keep = MASK_LOW;
        OP_ABOVE: if (!k.level_odd && margin_gt(py, c)) keep = MASK_HIGH;
        OP_CONTAINED: begin
          if (margin_lt(hi, c)) keep = MASK_LOW;
          else if (margin_gt(p, c)) keep = MASK_HIGH;
        end
        OP_INVALID: begin
          saw_bad_code = 1'b1;
          keep = MASK_NONE;
        end
        default: ;
      endcase
      live_children &= keep;
    end
    if (k.last_key) begin
      r.descend_low   = live_children[0];
      r.descend_high  = live_children[1];
      r.child_count   = 2'(live_children[0]) + 2'(live_children[1]);
      r.bad_condition = saw_bad_code;
      pending_verdicts.push_back(r);
      live_children = MASK_BOTH;
      saw_bad_code  = 1'b0;
    end
  endfunction

  function automatic in_item_t make_key(input logic [OpW-1:0] op,
                                        input logic signed [CoordW-1:0] c,
                                        input logic odd,
                                        input logic signed [CoordW-1:0] px,
                                        input logic signed [CoordW-1:0] py,
                                        input logic signed [CoordW-1:0] hx,
                                        input logic signed [CoordW-1:0] hy,
                                        input logic last);
    in_item_t k;
    k.opcode      = op;
    k.split_coord = c;
    k.level_odd   = odd;
    k.point_x     = px;
    k.point_y     = py;
    k.box_high_x  = hx;
    k.box_high_y  = hy;
    k.last_key    = last;
    return k;
  endfunction

  // a coordinate that often lands right at the margin boundary around c
  function automatic logic [CoordW-1:0] around_split(input logic [CoordW-1:0] c);
    logic [CoordW-1:0] d;
    d = {1'b0, margin} + 32'($urandom_range(0, 3)) - 32'd1;
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return c + d;
      2:       return c - d;
      3:       return c + 32'($urandom_range(0, 6)) - 32'd3;
      4:       return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
      default: return c;
    endcase
  endfunction

  function automatic in_item_t random_key(input logic last);
    in_item_t    k;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4)       k.opcode = OP_INVALID;
    else if (roll < 10) k.opcode = OP_NONE;
    else                k.opcode = 3'($urandom_range(OP_LEFT, OP_CONTAINED));
    if ($urandom_range(0, 7) == 0)
      k.split_coord = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    else
      k.split_coord = $urandom;
    k.level_odd  = 1'($urandom_range(0, 1));
    k.point_x    = around_split(k.split_coord);
    k.point_y    = around_split(k.split_coord);
    k.box_high_x = around_split(k.split_coord);
    k.box_high_y = around_split(k.split_coord);
    k.last_key   = last;
    return k;
  endfunction

  task automatic send_key(input in_item_t k);
    if (!calm)
      while ($urandom_range(0, 99) < 18) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_item  <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    prune_children(k);
    keys_sent++;
  endtask

  // only called between whole nodes, once every verdict is back
  task automatic set_margin(input logic [TolW-1:0] value);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    margin = value;
    margins_used++;
  endtask

  task automatic test_each_condition;
    send_key(make_key(OP_NONE, 0, 1, 0, 0, 0, 0, 1));
    send_key(make_key(OP_LEFT, COORD_MAX, 1, COORD_MIN, 5, 0, 0, 1));
    send_key(make_key(OP_LEFT, 100, 1, 100, 0, 0, 0, 1));
    send_key(make_key(OP_LEFT, COORD_MAX, 0, COORD_MIN, COORD_MIN, 0, 0, 1));
    send_key(make_key(OP_RIGHT, COORD_MIN, 1, COORD_MAX, 0, 0, 0, 1));
    send_key(make_key(OP_RIGHT, COORD_MIN, 0, COORD_MAX, COORD_MAX, 0, 0, 1));
    send_key(make_key(OP_BELOW, 0, 0, 7, COORD_MIN, 0, 0, 1));
    send_key(make_key(OP_BELOW, 0, 1, COORD_MIN, COORD_MIN, 0, 0, 1));
    send_key(make_key(OP_ABOVE, 0, 0, -7, COORD_MAX, 0, 0, 1));
    send_key(make_key(OP_ABOVE, 0, 1, COORD_MAX, COORD_MAX, 0, 0, 1));
    send_key(make_key(OP_SAME, 10, 1, 9, 50, 0, 0, 1));
    send_key(make_key(OP_SAME, -10, 0, -50, -9, 0, 0, 1));
    send_key(make_key(OP_SAME, -3, 1, -3, 0, 0, 0, 1));
    send_key(make_key(OP_CONTAINED, 0, 1, -20, 0, -1, 99, 1));
    send_key(make_key(OP_CONTAINED, 0, 0, -20, 1, 99, 99, 1));
    // inverted box: low corner above split, high corner below it
    send_key(make_key(OP_CONTAINED, 0, 1, 40, 0, -40, 0, 1));
    send_key(make_key(OP_CONTAINED, 0, 1, -40, 0, 40, 0, 1));
    send_key(make_key(OP_INVALID, $urandom, 1, $urandom, $urandom, $urandom, $urandom, 1));
    // mask emptied by valid keys; a later bad code must not raise the flag
    send_key(make_key(OP_LEFT, 0, 1, -1, 0, 0, 0, 0));
    send_key(make_key(OP_RIGHT, 0, 1, 1, 0, 0, 0, 0));
    send_key(make_key(OP_INVALID, 0, 1, 0, 0, 0, 0, 1));
    send_key(make_key(OP_INVALID, 0, 0, 0, 0, 0, 0, 0));
    send_key(make_key(OP_SAME, 0, 0, 0, -5, 0, 0, 1));
  endtask

  task automatic test_margin_extremes;
    set_margin(TOL_MAX);
    send_key(make_key(OP_LEFT, COORD_MAX, 1, COORD_MIN, 0, 0, 0, 1));
    send_key(make_key(OP_RIGHT, COORD_MIN, 1, COORD_MAX, 0, 0, 0, 1));
    send_key(make_key(OP_SAME, 0, 0, 0, COORD_MAX, 0, 0, 1));
    set_margin(31'd1);
    send_key(make_key(OP_LEFT, 0, 1, -1, 0, 0, 0, 1));
    send_key(make_key(OP_RIGHT, 0, 1, 2, 0, 0, 0, 1));
  endtask

  task automatic test_random_nodes;
    int unsigned sent;
    int unsigned len;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       set_margin('0);
        1:       set_margin(TolW'($urandom_range(1, 255)));
        2:       set_margin(TolW'($urandom));
        3:       set_margin(TOL_MAX);
        default: set_margin(TolW'($urandom_range(0, 65536)));
      endcase
      calm = (phase == 2);
      sent = 0;
      while (sent < 110) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          send_key(random_key(i == len - 1));
          sent++;
        end
      end
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || calm) out_stall <= 1'b0;
    else                out_stall <= ($urandom_range(0, 99) < 18);
  end

  // scoreboard: every result transfer against the oldest predicted verdict
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with nothing expected: %p", out_item);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        verdicts_checked++;
        if (out_item.descend_low !== want.descend_low) begin
          $error("descend_low: expected %0b, got %0b", want.descend_low, out_item.descend_low);
          mismatches++;
        end
        if (out_item.descend_high !== want.descend_high) begin
          $error("descend_high: expected %0b, got %0b", want.descend_high,
                 out_item.descend_high);
          mismatches++;
        end
        if (out_item.child_count !== want.child_count) begin
          $error("child_count: expected %0d, got %0d", want.child_count, out_item.child_count);
          mismatches++;
        end
        if (out_item.bad_condition !== want.bad_condition) begin
          $error("bad_condition: expected %0b, got %0b", want.bad_condition,
                 out_item.bad_condition);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_each_condition();
    test_margin_extremes();
    test_random_nodes();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d search keys and %0d node verdicts over %0d tolerance settings,",
             keys_sent, verdicts_checked, margins_used);
    $display("every condition code on both split axes, with random gaps and stalls.");
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
